// ----- rtl/vic_pkg.sv -----
package vic_pkg;

   localparam int DEFAULT_MAX_POINTS = 4096;

   localparam int CMD_W   = 2;
   localparam int ID_W    = 13;
   localparam int POS_W   = 12;
   localparam int COUNT_W = 13;
   localparam int RANK_W  = 12;

   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
   localparam logic [CMD_W-1:0] CMD_MARK  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_REMAP = 2'd2;

   localparam logic KIND_SUMMARY = 1'b0;
   localparam logic KIND_REMAP   = 1'b1;

   localparam logic [ID_W-1:0] GPC_RESET = 13'd4096;

   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic [ID_W-1:0]  point_id;
      logic             last;
   } req_type;

   typedef struct packed {
      logic               kind;
      logic [RANK_W-1:0]  local_index;
      logic [COUNT_W-1:0] unique_count;
      logic [POS_W-1:0]   lowest_pos;
      logic [POS_W-1:0]   highest_pos;
      logic               error;
   } rsp_type;

endpackage

// ----- rtl/vic_ram.sv -----
module vic_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/vertex_index_compaction.sv -----
// channel | direction | handshake            | beat payload
// req     | in        | req_valid, req_stall | req_type: cmd, point_id, last
// rsp     | out       | rsp_valid, rsp_stall | rsp_type: kind, local_index, unique_count,
//         |           |                      |   lowest_pos, highest_pos, error
// csr     | in        | csr_wr_en            | global_point_count (13 bits)
//
// a mark beat is a read-modify-write on the usage bitmap ram; a remap beat reads
// the usage bitmap and the rank ram. a last mark adds a walk over the bitmap,
// one entry a cycle, before the summary. a clear beat, and reset, start a sweep
// that zeroes the bitmap one entry a cycle; req_stall stays high during it. a
// result waits in the output register while rsp_stall is high; the next beat is
// still taken.
module vertex_index_compaction
   import vic_pkg::*;
#(
   parameter int MAX_POINTS = DEFAULT_MAX_POINTS
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_type          rsp_data,
   input  logic             csr_wr_en,
   input  logic [ID_W-1:0]  csr_wr_data
);

   localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int LW = (AW + 1 > ID_W) ? AW + 1 : ID_W;
   localparam logic [AW-1:0] LAST_POS = AW'(MAX_POINTS - 1);

   localparam logic [2:0] S_CLR  = 3'd0;
   localparam logic [2:0] S_IDLE = 3'd1;
   localparam logic [2:0] S_MARK = 3'd2;
   localparam logic [2:0] S_RMAP = 3'd3;
   localparam logic [2:0] S_WALK = 3'd4;
   localparam logic [2:0] S_TAIL = 3'd5;
   localparam logic [2:0] S_EMIT = 3'd6;

   logic [2:0]        state_ff, state_in;
   logic [ID_W-1:0]   gpc_ff;
   logic [AW-1:0]     cnt_ff, cnt_in;
   logic [AW-1:0]     pos_ff, pos_in;
   logic              id_ok_ff, id_ok_in;
   logic              last_ff, last_in;
   logic              pend_ff, pend_in;
   logic [AW-1:0]     pend_pos_ff, pend_pos_in;
   logic [AW:0]       distinct_ff, distinct_in;
   logic [AW-1:0]     low_ff, low_in;
   logic [AW-1:0]     high_ff, high_in;
   logic              any_ff, any_in;
   logic              bad_ff, bad_in;
   logic [AW-1:0]     rank_ff, rank_in;
   logic              kind_ff, kind_in;
   logic [RANK_W-1:0] loc_ff, loc_in;
   logic              err_ff, err_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   logic              accept;
   logic              out_free;
   logic              req_id_ok;
   logic [AW-1:0]     req_pos;

   logic              use_wr_en, use_wr_data, use_rd;
   logic [AW-1:0]     use_wr_addr, use_rd_addr;
   logic              rank_wr_en;
   logic [RANK_W-1:0] rank_rd;

   vic_ram #(.WIDTH(1), .DEPTH(MAX_POINTS)) u_usage (
      .clock   (clock),
      .wr_en   (use_wr_en),
      .wr_addr (use_wr_addr),
      .wr_data (use_wr_data),
      .rd_addr (use_rd_addr),
      .rd_data (use_rd)
   );

   vic_ram #(.WIDTH(RANK_W), .DEPTH(MAX_POINTS)) u_rank (
      .clock   (clock),
      .wr_en   (rank_wr_en),
      .wr_addr (pend_pos_ff),
      .wr_data (RANK_W'(rank_ff)),
      .rd_addr (req_pos),
      .rd_data (rank_rd)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // id limit is the register saturated at the bitmap depth
   assign req_id_ok = (req_data.point_id != '0)
                      && (LW'(req_data.point_id) <= LW'(gpc_ff))
                      && (LW'(req_data.point_id) <= LW'(MAX_POINTS));
   assign req_pos   = AW'(req_data.point_id - ID_W'(1));

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      pos_in       = pos_ff;
      id_ok_in     = id_ok_ff;
      last_in      = last_ff;
      pend_in      = pend_ff;
      pend_pos_in  = pend_pos_ff;
      distinct_in  = distinct_ff;
      low_in       = low_ff;
      high_in      = high_ff;
      any_in       = any_ff;
      bad_in       = bad_ff;
      rank_in      = rank_ff;
      kind_in      = kind_ff;
      loc_in       = loc_ff;
      err_in       = err_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      use_wr_en    = 1'b0;
      use_wr_addr  = cnt_ff;
      use_wr_data  = 1'b0;
      use_rd_addr  = req_pos;
      rank_wr_en   = 1'b0;

      // walk pipeline: the read issued last cycle lands now
      if (pend_ff && use_rd) begin
         rank_wr_en = 1'b1;
         rank_in    = rank_ff + AW'(1);
         high_in    = pend_pos_ff;
         any_in     = 1'b1;
         if (!any_ff) begin
            low_in = pend_pos_ff;
         end
      end

      unique case (state_ff)
         S_CLR: begin
            use_wr_en = 1'b1;
            cnt_in    = cnt_ff + AW'(1);
            if (cnt_ff == LAST_POS) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               pos_in   = req_pos;
               id_ok_in = req_id_ok;
               last_in  = req_data.last;
               case (req_data.cmd)
                  CMD_CLEAR: begin
                     distinct_in = '0;
                     low_in      = '0;
                     high_in     = '0;
                     bad_in      = 1'b0;
                     cnt_in      = '0;
                     state_in    = S_CLR;
                  end
                  CMD_MARK:  state_in = S_MARK;
                  CMD_REMAP: state_in = S_RMAP;
                  default:   state_in = S_IDLE;
               endcase
            end
         end
         S_MARK: begin
            use_wr_addr = pos_ff;
            use_wr_data = 1'b1;
            if (!id_ok_ff) begin
               bad_in = 1'b1;
            end else if (!use_rd) begin
               use_wr_en   = 1'b1;
               distinct_in = distinct_ff + (AW+1)'(1);
            end
            if (last_ff) begin
               cnt_in   = '0;
               pend_in  = 1'b0;
               any_in   = 1'b0;
               low_in   = '0;
               high_in  = '0;
               rank_in  = '0;
               state_in = S_WALK;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_RMAP: begin
            kind_in  = KIND_REMAP;
            err_in   = !(id_ok_ff && use_rd);
            loc_in   = (id_ok_ff && use_rd) ? rank_rd : '0;
            state_in = S_EMIT;
         end
         S_WALK: begin
            use_rd_addr = cnt_ff;
            pend_in     = 1'b1;
            pend_pos_in = cnt_ff;
            cnt_in      = cnt_ff + AW'(1);
            if (cnt_ff == LAST_POS) begin
               state_in = S_TAIL;
            end
         end
         S_TAIL: begin
            pend_in  = 1'b0;
            kind_in  = KIND_SUMMARY;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in.kind = kind_ff;
               if (kind_ff == KIND_REMAP) begin
                  rsp_data_in.local_index  = loc_ff;
                  rsp_data_in.unique_count = '0;
                  rsp_data_in.lowest_pos   = '0;
                  rsp_data_in.highest_pos  = '0;
                  rsp_data_in.error        = err_ff;
               end else begin
                  rsp_data_in.local_index  = '0;
                  rsp_data_in.unique_count = COUNT_W'(distinct_ff);
                  rsp_data_in.lowest_pos   = POS_W'(low_ff);
                  rsp_data_in.highest_pos  = POS_W'(high_ff);
                  rsp_data_in.error        = bad_ff;
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         cnt_ff       <= '0;
         gpc_ff       <= GPC_RESET;
         pend_ff      <= 1'b0;
         distinct_ff  <= '0;
         low_ff       <= '0;
         high_ff      <= '0;
         any_ff       <= 1'b0;
         bad_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         pend_ff      <= pend_in;
         distinct_ff  <= distinct_in;
         low_ff       <= low_in;
         high_ff      <= high_in;
         any_ff       <= any_in;
         bad_ff       <= bad_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            gpc_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      pos_ff      <= pos_in;
      id_ok_ff    <= id_ok_in;
      last_ff     <= last_in;
      pend_pos_ff <= pend_pos_in;
      rank_ff     <= rank_in;
      kind_ff     <= kind_in;
      loc_ff      <= loc_in;
      err_ff      <= err_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule
